@@ rtl/tes_pkg.sv @@
// shared widths, lane indexes and helpers for the triangle element stiffness block
// no dependencies
package tes_pkg;

  localparam int CW     = 16;       // coordinate and coefficient width
  localparam int RW     = 32;       // result width
  localparam int DIF_W  = CW + 1;   // vertex differences b, c
  localparam int PRD_W  = 2 * DIF_W;
  localparam int DET_W  = PRD_W + 1; // det and b*b + c*c
  localparam int MQ_W   = DET_W + CW; // det*q, det*f
  localparam int NUM_W  = 50;       // divider dividend: 2*|num| + |den|
  localparam int DEN_W  = DET_W;    // divider divisor: 2*|den|
  localparam int VAL_W  = NUM_W + 1; // signed quotient
  localparam int ACC_W  = VAL_W + 1; // grad - mass
  localparam int NLANES = 9;
  localparam int NGRAD  = 6;        // gradient lanes, one divider each
  localparam int NCONST = 3;        // mass and load lanes, constant divisors

  // lanes 0..5 carry the gradient terms in output order k00,k11,k22,k01,k02,k12
  localparam int LN_MASS_DIAG = 6;
  localparam int LN_MASS_OFF  = 7;
  localparam int LN_LOAD      = 8;

  // constant lanes in the same order as lanes 6..8
  localparam int CQ_DIAG = 0;
  localparam int CQ_OFF  = 1;
  localparam int CQ_LOAD = 2;

  // divisors are 3 * 2^k: add half the divisor, shift by k, then divide by three
  localparam logic [MQ_W-1:0] DIAG_RND = MQ_W'(1536);
  localparam logic [MQ_W-1:0] OFF_RND  = MQ_W'(3072);
  localparam logic [MQ_W-1:0] LOAD_RND = MQ_W'(768);
  localparam int DIAG_SH = 10;
  localparam int OFF_SH  = 11;
  localparam int LOAD_SH = 9;

  // divide by three: t = th*2^20 + tl gives t/3 = th*349525 + (th + tl)/3
  localparam int CT_W    = 40;      // shifted dividend and quotient
  localparam int CT_LO_W = 20;
  localparam int HP_W    = 39;      // th * 349525
  localparam int U_W     = 21;      // th + tl
  localparam int LP_W    = 42;      // (th + tl) * ceil(2^22 / 3)
  localparam int DIV3_SH = 22;
  localparam logic [HP_W-1:0] DIV3_HI = HP_W'(349525);
  localparam logic [LP_W-1:0] DIV3_LO = LP_W'(1398102);

  typedef struct packed {
    logic [NLANES-1:0] neg;
    logic              zero;
  } side_t;

  function automatic logic [RW-1:0] sat_res(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] maxv;
    logic signed [ACC_W-1:0] minv;
    maxv = {{(ACC_W-RW+1){1'b0}}, {(RW-1){1'b1}}};
    minv = ~maxv;
    if (v > maxv) begin
      return maxv[RW-1:0];
    end else if (v < minv) begin
      return minv[RW-1:0];
    end
    return v[RW-1:0];
  endfunction

endpackage

@@ rtl/triangle_element_stiffness.sv @@
// top level: element stiffness matrix and load term of a linear triangle
// depends on tes_pkg and tes_div_lane
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  in      | sink      | in_valid_i / in_stall_o | x0..y2, q_avg, f_avg (Q8.8)
//  out     | source    | out_valid_o/out_stall_i | k00..k12, load_term (Q16.16), degenerate
//
// one item enters per cycle while not stalled; five arithmetic stages, fifty
// divider stages that each settle one quotient bit, one output register
// the divider stages set the depth: six divider lanes for the gradient quotients;
// the mass and load divisors are three times a power of two, so those quotients
// take a shift and two short reciprocal products and then wait in a delay line
// reset clears only the valid bits; data registers are not reset
// a stall on the output while its register is full freezes the whole pipeline
// and raises in_stall_o in the same cycle, so no item is dropped or repeated
module triangle_element_stiffness (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [tes_pkg::CW-1:0] x0_i,
  input  logic signed [tes_pkg::CW-1:0] y0_i,
  input  logic signed [tes_pkg::CW-1:0] x1_i,
  input  logic signed [tes_pkg::CW-1:0] y1_i,
  input  logic signed [tes_pkg::CW-1:0] x2_i,
  input  logic signed [tes_pkg::CW-1:0] y2_i,
  input  logic signed [tes_pkg::CW-1:0] q_avg_i,
  input  logic signed [tes_pkg::CW-1:0] f_avg_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [tes_pkg::RW-1:0] k00_o,
  output logic signed [tes_pkg::RW-1:0] k11_o,
  output logic signed [tes_pkg::RW-1:0] k22_o,
  output logic signed [tes_pkg::RW-1:0] k01_o,
  output logic signed [tes_pkg::RW-1:0] k02_o,
  output logic signed [tes_pkg::RW-1:0] k12_o,
  output logic signed [tes_pkg::RW-1:0] load_term_o,
  output logic                          degenerate_o
);

  localparam int PJ [6] = '{0, 1, 2, 0, 0, 1};
  localparam int PK [6] = '{0, 1, 2, 1, 2, 2};

  logic en;
  logic out_valid_q;

  // pipeline moves unless the output register is full and stalled
  assign en         = ~(out_valid_q & out_stall_i);
  assign in_stall_o = ~en;

  // stage a: edge differences b_j, c_j
  logic                              va_q;
  logic signed [tes_pkg::DIF_W-1:0]  b_q [3];
  logic signed [tes_pkg::DIF_W-1:0]  c_q [3];
  logic signed [tes_pkg::CW-1:0]     qa_q, fa_q;

  function automatic logic signed [tes_pkg::DIF_W-1:0] sub_ext(
      logic signed [tes_pkg::CW-1:0] a, logic signed [tes_pkg::CW-1:0] b);
    return tes_pkg::DIF_W'(a) - tes_pkg::DIF_W'(b);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_q[0] <= sub_ext(y1_i, y2_i);
      b_q[1] <= sub_ext(y2_i, y0_i);
      b_q[2] <= sub_ext(y0_i, y1_i);
      c_q[0] <= sub_ext(x2_i, x1_i);
      c_q[1] <= sub_ext(x0_i, x2_i);
      c_q[2] <= sub_ext(x1_i, x0_i);
      qa_q   <= q_avg_i;
      fa_q   <= f_avg_i;
    end
  end

  // stage b: products for det and for b_j*b_k, c_j*c_k
  logic                             vb_q;
  logic signed [tes_pkg::PRD_W-1:0] pd1_q, pd2_q;
  logic signed [tes_pkg::PRD_W-1:0] bb_q [6];
  logic signed [tes_pkg::PRD_W-1:0] cc_q [6];
  logic signed [tes_pkg::CW-1:0]    qb_q, fb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // det = c2*b1 - c1*b2, the same as the vertex form
      pd1_q <= c_q[2] * b_q[1];
      pd2_q <= c_q[1] * b_q[2];
      for (int i = 0; i < 6; i++) begin
        bb_q[i] <= b_q[PJ[i]] * b_q[PK[i]];
        cc_q[i] <= c_q[PJ[i]] * c_q[PK[i]];
      end
      qb_q <= qa_q;
      fb_q <= fa_q;
    end
  end

  // stage c: det and the gradient numerators
  logic                             vc_q;
  logic signed [tes_pkg::DET_W-1:0] dc_q;
  logic signed [tes_pkg::DET_W-1:0] nc_q [6];
  logic signed [tes_pkg::CW-1:0]    qc_q, fc_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dc_q <= tes_pkg::DET_W'(pd1_q) - tes_pkg::DET_W'(pd2_q);
      for (int i = 0; i < 6; i++) begin
        nc_q[i] <= tes_pkg::DET_W'(bb_q[i]) + tes_pkg::DET_W'(cc_q[i]);
      end
      qc_q <= qb_q;
      fc_q <= fb_q;
    end
  end

  // stage d: det*q and det*f
  logic                             vd_q;
  logic signed [tes_pkg::DET_W-1:0] dd_q;
  logic signed [tes_pkg::DET_W-1:0] nd_q [6];
  logic signed [tes_pkg::MQ_W-1:0]  dq_q, df_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dd_q <= dc_q;
      nd_q <= nc_q;
      dq_q <= dc_q * qc_q;
      df_q <= dc_q * fc_q;
    end
  end

  // stage e: magnitudes, signs and divider operands
  // rounding to nearest: quotient = (2|n| + |d|) / (2|d|)
  logic                             ve_q;
  logic [tes_pkg::NUM_W-1:0]        num_q [tes_pkg::NGRAD];
  logic [tes_pkg::DEN_W-1:0]        den_q [tes_pkg::NGRAD];
  logic [tes_pkg::CT_W-1:0]         ct_q  [tes_pkg::NCONST];
  tes_pkg::side_t                   side_e_q;

  logic [tes_pkg::DET_W-1:0] ad, an [6];
  logic [tes_pkg::MQ_W-1:0]  aq, af;
  logic [tes_pkg::MQ_W-1:0]  rd, ro, rl;

  always_comb begin
    ad = dd_q[tes_pkg::DET_W-1] ? tes_pkg::DET_W'(-dd_q) : tes_pkg::DET_W'(dd_q);
    for (int i = 0; i < 6; i++) begin
      an[i] = nd_q[i][tes_pkg::DET_W-1] ? tes_pkg::DET_W'(-nd_q[i])
                                        : tes_pkg::DET_W'(nd_q[i]);
    end
    aq = dq_q[tes_pkg::MQ_W-1] ? tes_pkg::MQ_W'(-dq_q) : tes_pkg::MQ_W'(dq_q);
    af = df_q[tes_pkg::MQ_W-1] ? tes_pkg::MQ_W'(-df_q) : tes_pkg::MQ_W'(df_q);
    // half the divisor added, then the power-of-two part shifted out
    rd = aq + tes_pkg::DIAG_RND;
    ro = aq + tes_pkg::OFF_RND;
    rl = af + tes_pkg::LOAD_RND;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        // gradient numerator is n * 2^15, doubled for rounding
        num_q[i] <= {an[i][tes_pkg::DET_W-2:0], 16'b0} + tes_pkg::NUM_W'(ad);
        den_q[i] <= {ad[tes_pkg::DET_W-2:0], 1'b0};
        side_e_q.neg[i] <= nd_q[i][tes_pkg::DET_W-1] ^ dd_q[tes_pkg::DET_W-1];
      end
      ct_q[tes_pkg::CQ_DIAG] <= rd[tes_pkg::DIAG_SH +: tes_pkg::CT_W];
      ct_q[tes_pkg::CQ_OFF]  <= ro[tes_pkg::OFF_SH +: tes_pkg::CT_W];
      ct_q[tes_pkg::CQ_LOAD] <= rl[tes_pkg::LOAD_SH +: tes_pkg::CT_W];
      side_e_q.neg[tes_pkg::LN_MASS_DIAG] <= dq_q[tes_pkg::MQ_W-1];
      side_e_q.neg[tes_pkg::LN_MASS_OFF]  <= dq_q[tes_pkg::MQ_W-1];
      // load term is -det*f: negative when det*f is positive (zero quotient is sign-free)
      side_e_q.neg[tes_pkg::LN_LOAD]      <= ~df_q[tes_pkg::MQ_W-1];
      side_e_q.zero <= (dd_q == '0);
    end
  end

  // valid bits of the arithmetic stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  // divider lanes for the gradient quotients
  logic [tes_pkg::NUM_W-1:0] quot [tes_pkg::NGRAD];

  for (genvar l = 0; l < tes_pkg::NGRAD; l++) begin : g_lane
    tes_div_lane u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num_q[l]),
      .den_i  (den_q[l]),
      .quot_o (quot[l])
    );
  end

  // mass and load quotients: divide by three in two stages, then delay to line up
  // with the divider output (first stage beside divider stage 0, delay ends beside 49)
  logic [tes_pkg::HP_W-1:0] hp_q [tes_pkg::NCONST];
  logic [tes_pkg::U_W-1:0]  u_q  [tes_pkg::NCONST];
  logic [tes_pkg::LP_W-1:0] lp   [tes_pkg::NCONST];
  logic [tes_pkg::CT_W-1:0] cq_q [tes_pkg::NUM_W-1][tes_pkg::NCONST];

  always_comb begin
    for (int c = 0; c < tes_pkg::NCONST; c++) begin
      lp[c] = tes_pkg::LP_W'(u_q[c]) * tes_pkg::DIV3_LO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < tes_pkg::NCONST; c++) begin
        // 20 by 19 bit product for the high half
        hp_q[c] <= tes_pkg::HP_W'(ct_q[c][tes_pkg::CT_W-1:tes_pkg::CT_LO_W])
                   * tes_pkg::DIV3_HI;
        u_q[c]  <= tes_pkg::U_W'(ct_q[c][tes_pkg::CT_W-1:tes_pkg::CT_LO_W])
                   + tes_pkg::U_W'(ct_q[c][tes_pkg::CT_LO_W-1:0]);
        cq_q[0][c] <= tes_pkg::CT_W'(hp_q[c])
                      + tes_pkg::CT_W'(lp[c][tes_pkg::LP_W-1:tes_pkg::DIV3_SH]);
      end
      for (int s = 1; s < tes_pkg::NUM_W - 1; s++) begin
        cq_q[s] <= cq_q[s-1];
      end
    end
  end

  // signs, degenerate flag and valid bits ride alongside the divider
  logic           vdl_q   [tes_pkg::NUM_W];
  tes_pkg::side_t sidel_q [tes_pkg::NUM_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < tes_pkg::NUM_W; s++) begin
        vdl_q[s] <= 1'b0;
      end
    end else if (en) begin
      vdl_q[0] <= ve_q;
      for (int s = 1; s < tes_pkg::NUM_W; s++) begin
        vdl_q[s] <= vdl_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sidel_q[0] <= side_e_q;
      for (int s = 1; s < tes_pkg::NUM_W; s++) begin
        sidel_q[s] <= sidel_q[s-1];
      end
    end
  end

  // final stage: apply signs, subtract the mass term, saturate, zero when det is zero
  tes_pkg::side_t                   side_f;
  logic signed [tes_pkg::VAL_W-1:0] sval [tes_pkg::NLANES];
  logic signed [tes_pkg::ACC_W-1:0] kacc [6];
  logic [tes_pkg::RW-1:0]           kres [6];
  logic [tes_pkg::RW-1:0]           load_res;

  assign side_f = sidel_q[tes_pkg::NUM_W-1];

  always_comb begin
    for (int l = 0; l < tes_pkg::NGRAD; l++) begin
      sval[l] = side_f.neg[l] ? -tes_pkg::VAL_W'(quot[l]) : tes_pkg::VAL_W'(quot[l]);
    end
    // constant lanes map onto lanes 6..8 in order
    for (int c = 0; c < tes_pkg::NCONST; c++) begin
      sval[tes_pkg::LN_MASS_DIAG + c] =
          side_f.neg[tes_pkg::LN_MASS_DIAG + c]
          ? -tes_pkg::VAL_W'(cq_q[tes_pkg::NUM_W-2][c])
          : tes_pkg::VAL_W'(cq_q[tes_pkg::NUM_W-2][c]);
    end
    for (int i = 0; i < 6; i++) begin
      kacc[i] = tes_pkg::ACC_W'(sval[i])
              - tes_pkg::ACC_W'((PJ[i] == PK[i]) ? sval[tes_pkg::LN_MASS_DIAG]
                                                 : sval[tes_pkg::LN_MASS_OFF]);
      kres[i] = side_f.zero ? '0 : tes_pkg::sat_res(kacc[i]);
    end
    load_res = side_f.zero ? '0
             : tes_pkg::sat_res(tes_pkg::ACC_W'(sval[tes_pkg::LN_LOAD]));
  end

  logic [tes_pkg::RW-1:0] k_q [6];
  logic [tes_pkg::RW-1:0] load_q;
  logic                   degen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vdl_q[tes_pkg::NUM_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      k_q     <= kres;
      load_q  <= load_res;
      degen_q <= side_f.zero;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign k00_o        = k_q[0];
  assign k11_o        = k_q[1];
  assign k22_o        = k_q[2];
  assign k01_o        = k_q[3];
  assign k02_o        = k_q[4];
  assign k12_o        = k_q[5];
  assign load_term_o  = load_q;
  assign degenerate_o = degen_q;

endmodule

@@ rtl/tes_div_lane.sv @@
// pipelined restoring divider lane, one quotient bit per stage
// depends on tes_pkg
module tes_div_lane (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [tes_pkg::NUM_W-1:0] num_i,
  input  logic [tes_pkg::DEN_W-1:0] den_i,
  output logic [tes_pkg::NUM_W-1:0] quot_o
);

  logic [tes_pkg::NUM_W-1:0] num_q  [tes_pkg::NUM_W];
  logic [tes_pkg::DEN_W-1:0] den_q  [tes_pkg::NUM_W];
  logic [tes_pkg::DEN_W-1:0] rem_q  [tes_pkg::NUM_W];
  logic [tes_pkg::NUM_W-1:0] quot_q [tes_pkg::NUM_W];

  for (genvar s = 0; s < tes_pkg::NUM_W; s++) begin : g_stage
    logic [tes_pkg::NUM_W-1:0] num_c, quot_c;
    logic [tes_pkg::DEN_W-1:0] den_c, rem_c;
    logic [tes_pkg::DEN_W:0]   trial, diff;
    logic                      ge;

    if (s == 0) begin : g_first
      assign num_c  = num_i;
      assign den_c  = den_i;
      assign rem_c  = '0;
      assign quot_c = '0;
    end else begin : g_next
      assign num_c  = num_q[s-1];
      assign den_c  = den_q[s-1];
      assign rem_c  = rem_q[s-1];
      assign quot_c = quot_q[s-1];
    end

    assign trial = {rem_c, num_c[tes_pkg::NUM_W-1]};
    assign diff  = trial - {1'b0, den_c};
    assign ge    = ~diff[tes_pkg::DEN_W];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s]  <= {num_c[tes_pkg::NUM_W-2:0], 1'b0};
        den_q[s]  <= den_c;
        rem_q[s]  <= ge ? diff[tes_pkg::DEN_W-1:0] : trial[tes_pkg::DEN_W-1:0];
        quot_q[s] <= {quot_c[tes_pkg::NUM_W-2:0], ge};
      end
    end
  end

  assign quot_o = quot_q[tes_pkg::NUM_W-1];

endmodule
